>>> hdl/plan_deviation_segment_tracker_defines.svh
// Assertion macros shared by the plan deviation segment tracker RTL.
// No dependencies; bodies are empty when SYNTHESIS is defined.
`ifndef PLAN_DEVIATION_SEGMENT_TRACKER_DEFINES_SVH
`define PLAN_DEVIATION_SEGMENT_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define PDST_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pdst: property violated");
`define PDST_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("pdst: forbidden condition");
`else
`define PDST_ASSERT(lbl, clk, rst_n, prop)
`define PDST_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> hdl/pdst_pkg.sv
// Types and constants of the plan deviation segment tracker.
// Used by the tracker front, the segment queue, the output stage and the top level.
package pdst_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned MM_W   = 24;

	localparam logic [1:0] REG_PLAN_PRESENT = 2'd0;
	localparam logic [1:0] REG_XT_LIMIT     = 2'd1;
	localparam logic [1:0] REG_ALT_LIMIT    = 2'd2;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_EOT    = 1'b1;

	localparam logic KIND_DEV = 1'b0;
	localparam logic KIND_ALT = 1'b1;

	typedef struct packed {
		logic              plan_present;
		logic [MM_W-1:0]   xt_limit;
		logic [MM_W-1:0]   alt_limit;
	} cfg_t;

	typedef struct packed {
		logic                cmd;
		logic [TIME_W-1:0]   time_ms;
		logic                position_valid;
		logic                deviation_valid;
		logic [MM_W-1:0]     cross_track_mm;
		logic                altitude_error_valid;
		logic [MM_W-1:0]     altitude_error_mm;
	} item_t;

	typedef struct packed {
		logic                valid;
		logic                warn;
		logic [TIME_W-1:0]   start;
		logic [TIME_W-1:0]   stop;
		logic                has_end;
		logic [MM_W-1:0]     peak;
	} seg_t;

	typedef struct packed {
		seg_t dev;
		seg_t alt;
	} entry_t;

endpackage

>>> hdl/pdst_front.sv
// Tracker front: classifies each item and updates both excursion segments.
// Pushes closed segments into the queue as one entry. Depends on pdst_pkg.
module pdst_front (
	input  logic            clk,
	input  logic            arst_n,
	input  pdst_pkg::cfg_t  cfg,
	input  logic            in_valid,
	input  pdst_pkg::item_t in_item,
	input  logic            q_full,
	output logic            q_wr_en,
	output pdst_pkg::entry_t q_wr_data
);
	import pdst_pkg::*;

	logic                accept;
	logic                sample_ok;
	logic [MM_W-1:0]     amag;
	logic                hit_dev, hit_alt;
	logic                sev_dev, sev_alt;
	logic                close_dev, close_alt;

	logic                dev_open_q, alt_open_q;
	logic                dev_warn_q, alt_warn_q;
	logic                dev_seen_q, alt_seen_q;
	logic [TIME_W-1:0]   dev_start_q, alt_start_q;
	logic [TIME_W-1:0]   dev_end_q, alt_end_q;
	logic [MM_W-1:0]     dev_peak_q, alt_peak_q;

	assign accept    = in_valid && !q_full;
	assign sample_ok = (in_item.cmd == CMD_SAMPLE) && in_item.position_valid
		&& in_item.deviation_valid;
	assign amag = in_item.altitude_error_mm[MM_W-1]
		? MM_W'(~in_item.altitude_error_mm + 1'b1) : in_item.altitude_error_mm;

	assign sev_dev = {1'b0, in_item.cross_track_mm} >= {cfg.xt_limit, 1'b0};
	assign sev_alt = {1'b0, amag} >= {cfg.alt_limit, 1'b0};
	assign hit_dev = sample_ok && (cfg.xt_limit != '0)
		&& (in_item.cross_track_mm >= cfg.xt_limit);
	assign hit_alt = sample_ok && (cfg.alt_limit != '0) && in_item.altitude_error_valid
		&& (amag >= cfg.alt_limit);
	assign close_dev = !hit_dev && dev_open_q;
	assign close_alt = !hit_alt && alt_open_q;

	assign q_wr_en = accept && cfg.plan_present && (close_dev || close_alt);

	always_comb begin
		q_wr_data.dev.valid   = close_dev;
		q_wr_data.dev.warn    = dev_warn_q;
		q_wr_data.dev.start   = dev_start_q;
		q_wr_data.dev.stop    = dev_end_q;
		q_wr_data.dev.has_end = dev_seen_q;
		q_wr_data.dev.peak    = dev_peak_q;
		q_wr_data.alt.valid   = close_alt;
		q_wr_data.alt.warn    = alt_warn_q;
		q_wr_data.alt.start   = alt_start_q;
		q_wr_data.alt.stop    = alt_end_q;
		q_wr_data.alt.has_end = alt_seen_q;
		q_wr_data.alt.peak    = alt_peak_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_open_q  <= 1'b0;
			dev_warn_q  <= 1'b0;
			dev_seen_q  <= 1'b0;
			dev_start_q <= '0;
			dev_end_q   <= '0;
			dev_peak_q  <= '0;
		end else if (accept) begin
			priority if (!cfg.plan_present) begin
				dev_open_q <= 1'b0;
			end else if (hit_dev && !dev_open_q) begin
				dev_open_q  <= 1'b1;
				dev_start_q <= in_item.time_ms;
				dev_end_q   <= '0;
				dev_seen_q  <= 1'b0;
				dev_peak_q  <= in_item.cross_track_mm;
				dev_warn_q  <= sev_dev;
			end else if (hit_dev) begin
				dev_end_q  <= in_item.time_ms;
				dev_seen_q <= 1'b1;
				if (in_item.cross_track_mm > dev_peak_q) begin
					dev_peak_q <= in_item.cross_track_mm;
				end
				dev_warn_q <= dev_warn_q | sev_dev;
			end else begin
				dev_open_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_open_q  <= 1'b0;
			alt_warn_q  <= 1'b0;
			alt_seen_q  <= 1'b0;
			alt_start_q <= '0;
			alt_end_q   <= '0;
			alt_peak_q  <= '0;
		end else if (accept) begin
			priority if (!cfg.plan_present) begin
				alt_open_q <= 1'b0;
			end else if (hit_alt && !alt_open_q) begin
				alt_open_q  <= 1'b1;
				alt_start_q <= in_item.time_ms;
				alt_end_q   <= '0;
				alt_seen_q  <= 1'b0;
				alt_peak_q  <= amag;
				alt_warn_q  <= sev_alt;
			end else if (hit_alt) begin
				alt_end_q  <= in_item.time_ms;
				alt_seen_q <= 1'b1;
				if (amag > alt_peak_q) begin
					alt_peak_q <= amag;
				end
				alt_warn_q <= alt_warn_q | sev_alt;
			end else begin
				alt_open_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/pdst_fifo.sv
// Short queue of closed-segment entries between the tracker front and output stage.
// Depends on pdst_pkg and the assertion macro header.
`include "plan_deviation_segment_tracker_defines.svh"
module pdst_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  pdst_pkg::entry_t wr_data,
	input  logic             rd_en,
	output pdst_pkg::entry_t rd_data,
	output logic             full,
	output logic             not_empty
);
	import pdst_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	entry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PDST_NEVER(a_no_write_full, clk, arst_n, wr_en && full)
	`PDST_NEVER(a_no_read_empty, clk, arst_n, rd_en && !not_empty)
	`PDST_ASSERT(a_fill_count, clk, arst_n, wr_en && !rd_en |=> count_q == $past(count_q) + 1'b1)
	`PDST_ASSERT(a_ptr_gap, clk, arst_n, !full && not_empty |-> wr_ptr_q != rd_ptr_q)

endmodule

>>> hdl/pdst_back.sv
// Output stage: holds one queue entry and hands out its segments, deviation first.
// Depends on pdst_pkg.
module pdst_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_not_empty,
	input  pdst_pkg::entry_t             q_rd_data,
	output logic                         q_rd_en,
	input  logic                         pop,
	output logic                         empty,
	output logic                         segment_kind,
	output logic                         severity,
	output logic [pdst_pkg::TIME_W-1:0]  start_time_ms,
	output logic [pdst_pkg::TIME_W-1:0]  end_time_ms,
	output logic                         has_end,
	output logic [pdst_pkg::MM_W-1:0]    peak_mm,
	output logic                         last
);
	import pdst_pkg::*;

	entry_t cur_q;
	seg_t   sel;
	logic   any, both, fire;

	assign any   = cur_q.dev.valid | cur_q.alt.valid;
	assign both  = cur_q.dev.valid & cur_q.alt.valid;
	assign fire  = pop && any;
	assign empty = !any;
	assign q_rd_en = q_not_empty && (!any || (fire && !both));

	assign sel           = cur_q.dev.valid ? cur_q.dev : cur_q.alt;
	assign segment_kind  = cur_q.dev.valid ? KIND_DEV : KIND_ALT;
	assign severity      = sel.warn;
	assign start_time_ms = sel.start;
	assign end_time_ms   = sel.stop;
	assign has_end       = sel.has_end;
	assign peak_mm       = sel.peak;
	assign last          = !both;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (q_rd_en) begin
			cur_q <= q_rd_data;
		end else if (fire) begin
			cur_q.dev.valid <= 1'b0;
			if (!both) begin
				cur_q.alt.valid <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/plan_deviation_segment_tracker.sv
// Plan deviation segment tracker: takes one track sample or end-of-track item per
// cycle whenever full is low; the tracker state updates in that same cycle. Each
// closed segment leaves on the result side with a pop of its own, so an item
// closing both segments needs two pops from the output stage. A queue of
// QUEUE_DEPTH entries sits between the tracker front and the output stage, and
// full rises only when that queue is full. No clearing pass after reset.
module plan_deviation_segment_tracker #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         push,
	output logic         full,
	input  logic         cmd,
	input  logic [31:0]  time_ms,
	input  logic         position_valid,
	input  logic         deviation_valid,
	input  logic [23:0]  cross_track_mm,
	input  logic         altitude_error_valid,
	input  logic signed [23:0] altitude_error_mm,
	output logic         empty,
	input  logic         pop,
	output logic         segment_kind,
	output logic         severity,
	output logic [31:0]  start_time_ms,
	output logic [31:0]  end_time_ms,
	output logic         has_end,
	output logic [23:0]  peak_mm,
	output logic         last
);
	import pdst_pkg::*;

	cfg_t        cfg_q;
	item_t       item;
	logic        cfg_wr;
	logic [1:0]  reg_idx;
	logic        q_wr_en, q_rd_en, q_full, q_not_empty;
	entry_t      q_wr_data, q_rd_data;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_PLAN_PRESENT: cfg_q.plan_present <= pwdata[0];
				REG_XT_LIMIT:     cfg_q.xt_limit     <= pwdata[MM_W-1:0];
				REG_ALT_LIMIT:    cfg_q.alt_limit    <= pwdata[MM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PLAN_PRESENT: prdata = {31'd0, cfg_q.plan_present};
			REG_XT_LIMIT:     prdata = {8'd0, cfg_q.xt_limit};
			REG_ALT_LIMIT:    prdata = {8'd0, cfg_q.alt_limit};
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		item.cmd                  = cmd;
		item.time_ms              = time_ms;
		item.position_valid       = position_valid;
		item.deviation_valid      = deviation_valid;
		item.cross_track_mm       = cross_track_mm;
		item.altitude_error_valid = altitude_error_valid;
		item.altitude_error_mm    = altitude_error_mm;
	end

	assign full = q_full;

	pdst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (push),
		.in_item   (item),
		.q_full    (q_full),
		.q_wr_en   (q_wr_en),
		.q_wr_data (q_wr_data)
	);

	pdst_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (q_wr_en),
		.wr_data   (q_wr_data),
		.rd_en     (q_rd_en),
		.rd_data   (q_rd_data),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	pdst_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_rd_data     (q_rd_data),
		.q_rd_en       (q_rd_en),
		.pop           (pop),
		.empty         (empty),
		.segment_kind  (segment_kind),
		.severity      (severity),
		.start_time_ms (start_time_ms),
		.end_time_ms   (end_time_ms),
		.has_end       (has_end),
		.peak_mm       (peak_mm),
		.last          (last)
	);

endmodule
